[rtl/tts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared geometry, widths, opcodes and memory port types of the scrollback
// engine.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_COLS  = 80;
  localparam int HISTORY_ROWS = 128;

  localparam int ROW_W      = $clog2(HISTORY_ROWS);
  localparam int USED_W     = $clog2(HISTORY_ROWS + 1);
  localparam int COL_W      = $clog2(SCREEN_COLS + 1);
  localparam int CELL_DEPTH = HISTORY_ROWS * SCREEN_COLS;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  typedef enum logic [3:0] {
    OP_PUT      = 4'd0,
    OP_LEFT     = 4'd1,
    OP_RIGHT    = 4'd2,
    OP_SET_OFF  = 4'd3,
    OP_SET_ABS  = 4'd4,
    OP_PAGE_UP  = 4'd5,
    OP_PAGE_DN  = 4'd6,
    OP_CLEAR    = 4'd7,
    OP_READ     = 4'd8
  } opcode_t;

  typedef struct packed {
    logic             wrapped;
    logic [COL_W-1:0] len;
  } row_info_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    logic [15:0]        data;
  } cell_wr_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] addr;
    row_info_t        data;
  } row_wr_t;

endpackage

[rtl/tts_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_store
// Cell store and per-row length/wrap store, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module tts_store (
  input  logic                         clk,
  input  tts_pkg::cell_wr_t            cell_wr,
  input  logic [tts_pkg::CELL_AW-1:0]  cell_raddr,
  output logic [15:0]                  cell_rdata,
  input  tts_pkg::row_wr_t             row_wr,
  input  logic [tts_pkg::ROW_W-1:0]    row_raddr,
  output tts_pkg::row_info_t           row_rdata
);
  import tts_pkg::*;

  logic [15:0] cell_mem [CELL_DEPTH];
  row_info_t   row_mem  [HISTORY_ROWS];
  logic [15:0] cell_rdata_r;
  row_info_t   row_rdata_r;

  always_ff @(posedge clk) begin
    if (cell_wr.we) begin
      cell_mem[cell_wr.addr] <= cell_wr.data;
    end
    cell_rdata_r <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_wr.we) begin
      row_mem[row_wr.addr] <= row_wr.data;
    end
    row_rdata_r <= row_mem[row_raddr];
  end

  assign cell_rdata = cell_rdata_r;
  assign row_rdata  = row_rdata_r;

endmodule

[rtl/text_terminal_scrollback_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_scrollback_engine
// Text-mode terminal with a ring-based scrollback store of character cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transfer; in_tuser carries the opcode, in_tdata
//           the character, screen offset, absolute row/column and view cell.
//   out_* : one result per operation: the cell read (zero unless a read) and
//           the cursor, view top, rows in use and hardware cursor offset.
//   cfg_* : write enable and data for the cell attribute byte (reset 7);
//           write only while no operation is in flight.
// Steps: accept, memory read, execute, view snap, result register; the next
//   operation is taken once the engine is back in idle. Set offset adds a
//   divide step, one subtract of the column count per screen row of the
//   offset. Newline, wrap and a set offset that drops the oldest row add one
//   pass over a row, one cell per cycle through the single cell-store write
//   port.
// Clear, and reset, sweep the whole store; no operation is taken meanwhile
// (configuration writes still are).
// A finished result waits in the output register while the receiver stalls;
// the engine returns to idle and takes the next operation, but holds its
// next result until the register is free.
// ----------------------------------------------------------------------------
module text_terminal_scrollback_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] char_code, [18:8] screen_offset, [26:19] abs_row, [34:27] abs_col,
  // [39:35] view_row, [46:40] view_col, [47] zero
  input  logic [47:0] in_tdata,
  // [3:0] opcode
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] cell_value, [22:16] cursor_line, [29:23] cursor_column,
  // [36:30] view_top, [44:37] rows_in_use, [55:45] hw_cursor_offset
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import tts_pkg::*;

  localparam logic [7:0] ATTR_RESET   = 8'd7;
  localparam int         QUO_W        = $clog2(SCREEN_ROWS);
  localparam int         AW           = ((USED_W > 8) ? USED_W : 8) + 1;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_EXEC, S_DIV, S_SWEEP, S_SNAP, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [3:0]         op_r, op_nxt;
  logic [7:0]         ch_r, ch_nxt;
  logic [10:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [7:0]         abs_row_r, abs_row_nxt;
  logic [7:0]         abs_col_r, abs_col_nxt;
  logic [4:0]         vrow_r, vrow_nxt;
  logic [6:0]         vcol_r, vcol_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [ROW_W-1:0]   rb_r, rb_nxt;
  logic [7:0]         attr_r, attr_nxt;
  logic [15:0]        cell_r, cell_nxt;
  logic [ROW_W-1:0]   sw_row_r, sw_row_nxt;
  logic [COL_W-1:0]   sw_col_r, sw_col_nxt;
  logic               sw_all_r, sw_all_nxt;
  logic [7:0]         sw_attr_r, sw_attr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [55:0]        out_data_r, out_data_nxt;

  cell_wr_t           cell_wr;
  row_wr_t            row_wr;
  logic [CELL_AW-1:0] cell_raddr;
  logic [15:0]        cell_rdata;
  logic [ROW_W-1:0]   row_raddr;
  row_info_t          row_rdata;

  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W:0]     hr;
  logic               rd_oob;
  logic [COL_W-1:0]   rd_col;
  logic [ROW_W-1:0]   rb_inc;

  function automatic logic [ROW_W-1:0] phys(input logic [ROW_W-1:0] rb,
                                            input logic [ROW_W-1:0] row);
    logic [ROW_W:0] s;
    s = {1'b0, rb} + {1'b0, row};
    if (s >= (ROW_W+1)'(HISTORY_ROWS)) begin
      s = s - (ROW_W+1)'(HISTORY_ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] p,
                                                   input logic [COL_W-1:0] c);
    return CELL_AW'(p) * CELL_AW'(SCREEN_COLS) + CELL_AW'(c);
  endfunction

  function automatic logic [ROW_W-1:0] live_top(input logic [USED_W-1:0] used);
    if (used <= USED_W'(SCREEN_ROWS)) begin
      return '0;
    end
    return ROW_W'(used - USED_W'(SCREEN_ROWS));
  endfunction

  function automatic logic [ROW_W-1:0] keep_vis(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] lim;
    lim = {1'b0, top} + (ROW_W+1)'(SCREEN_ROWS);
    if (row < top) begin
      return row;
    end else if ({1'b0, row} >= lim) begin
      return row - ROW_W'(SCREEN_ROWS - 1);
    end
    return top;
  endfunction

  function automatic logic [COL_W-1:0] end_col(input row_info_t ri);
    if (ri.wrapped || ri.len > COL_W'(SCREEN_COLS - 1)) begin
      return COL_W'(SCREEN_COLS - 1);
    end
    return ri.len;
  endfunction

  tts_store u_store (
    .clk        (clk),
    .cell_wr    (cell_wr),
    .cell_raddr (cell_raddr),
    .cell_rdata (cell_rdata),
    .row_wr     (row_wr),
    .row_raddr  (row_raddr),
    .row_rdata  (row_rdata)
  );

  // Row to look up: the row above when stepping back from column zero.
  assign rd_row = (op_r == OP_RIGHT || cur_col_r != '0 || cur_row_r == '0) ?
                  cur_row_r : cur_row_r - 1'b1;
  assign row_raddr = phys(rb_r, rd_row);

  // Visible cell lookup for read operations.
  assign hr     = {1'b0, top_r} + (ROW_W+1)'(vrow_r);
  assign rd_oob = (vrow_r >= 5'(SCREEN_ROWS)) || (vcol_r >= 7'(SCREEN_COLS)) ||
                  ((ROW_W+1)'(used_r) <= hr) ||
                  (hr >= (ROW_W+1)'(HISTORY_ROWS));
  assign rd_col = (vcol_r >= 7'(SCREEN_COLS)) ? '0 : COL_W'(vcol_r);
  assign cell_raddr = cell_addr(phys(rb_r, hr[ROW_W-1:0]), rd_col);

  assign rb_inc = (rb_r == ROW_W'(HISTORY_ROWS - 1)) ? '0 : rb_r + 1'b1;

  always_comb begin
    logic               next_row;
    logic [ROW_W:0]     cand;
    logic [COL_W-1:0]   col_b;
    logic [COL_W:0]     col_p;
    logic [COL_W-1:0]   lim_r;
    logic [ROW_W:0]     sum;
    logic [ROW_W-1:0]   bottom;
    logic signed [AW-1:0] ar;
    logic signed [AW-1:0] au;
    logic [QUO_W-1:0]   diff;
    logic [10:0]        hw;
    logic               in_view;

    next_row = 1'b0;
    cand     = '0;
    col_b    = '0;
    col_p    = '0;
    lim_r    = '0;
    sum      = '0;
    bottom   = '0;
    ar       = '0;
    au       = '0;
    diff     = '0;
    hw       = '0;
    in_view  = 1'b0;

    state_nxt   = state_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    abs_row_nxt = abs_row_r;
    abs_col_nxt = abs_col_r;
    vrow_nxt    = vrow_r;
    vcol_nxt    = vcol_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    used_nxt    = used_r;
    top_nxt     = top_r;
    rb_nxt      = rb_r;
    cell_nxt    = cell_r;
    sw_row_nxt  = sw_row_r;
    sw_col_nxt  = sw_col_r;
    sw_all_nxt  = sw_all_r;
    sw_attr_nxt = sw_attr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    attr_nxt    = cfg_wr_en ? cfg_wr_data : attr_r;
    cell_wr     = '0;
    row_wr      = '0;

    unique case (state_r)
      S_INIT, S_SWEEP: begin
        // Blank one cell per cycle; reset the row info on the first column.
        cell_wr.we   = 1'b1;
        cell_wr.addr = cell_addr(sw_row_r, sw_col_r);
        cell_wr.data = {sw_attr_r, CH_SPACE};
        if (sw_col_r == '0) begin
          row_wr.we   = 1'b1;
          row_wr.addr = sw_row_r;
          row_wr.data = '0;
        end
        if (sw_col_r == COL_W'(SCREEN_COLS - 1)) begin
          sw_col_nxt = '0;
          if (sw_all_r && sw_row_r != ROW_W'(HISTORY_ROWS - 1)) begin
            sw_row_nxt = sw_row_r + 1'b1;
          end else begin
            state_nxt = (state_r == S_INIT) ? S_IDLE : S_SNAP;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          ch_nxt      = in_tdata[7:0];
          rem_nxt     = in_tdata[18:8];
          abs_row_nxt = in_tdata[26:19];
          abs_col_nxt = in_tdata[34:27];
          vrow_nxt    = in_tdata[39:35];
          vcol_nxt    = in_tdata[46:40];
          quo_nxt     = '0;
          cell_nxt    = '0;
          state_nxt   = S_RD;
        end
      end

      S_RD: begin
        // Wait out the store read latency; a set offset beyond the screen is clamped to the last cell.
        if (op_r == OP_SET_OFF && rem_r >= 11'(SCREEN_ROWS * SCREEN_COLS)) begin
          rem_nxt = 11'(SCREEN_ROWS * SCREEN_COLS - 1);
        end
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        state_nxt = S_SNAP;
        case (op_r)
          OP_PUT: begin
            if (ch_r == CH_NEWLINE) begin
              row_wr.we   = 1'b1;
              row_wr.addr = phys(rb_r, cur_row_r);
              row_wr.data = '{wrapped: 1'b0, len: cur_col_r};
              next_row    = 1'b1;
            end else if (ch_r == CH_BACKSPACE) begin
              if (cur_row_r != '0 || cur_col_r != '0) begin
                col_b = (cur_col_r != '0) ? cur_col_r - 1'b1 : end_col(row_rdata);
                cur_row_nxt = rd_row;
                cur_col_nxt = col_b;
                row_wr.we   = 1'b1;
                row_wr.addr = row_raddr;
                if (row_rdata.wrapped && col_b == COL_W'(SCREEN_COLS - 1)) begin
                  row_wr.data = '{wrapped: 1'b0, len: COL_W'(SCREEN_COLS - 1)};
                end else begin
                  row_wr.data = '{wrapped: row_rdata.wrapped, len: col_b};
                end
                cell_wr.we   = 1'b1;
                cell_wr.addr = cell_addr(row_raddr, col_b);
                cell_wr.data = {attr_r, CH_SPACE};
              end
            end else begin
              col_p = {1'b0, cur_col_r} + 1'b1;
              cell_wr.we   = 1'b1;
              cell_wr.addr = cell_addr(phys(rb_r, cur_row_r), cur_col_r);
              cell_wr.data = {attr_r, ch_r};
              row_wr.we    = 1'b1;
              row_wr.addr  = phys(rb_r, cur_row_r);
              cur_col_nxt  = col_p[COL_W-1:0];
              if (col_p >= (COL_W+1)'(SCREEN_COLS)) begin
                row_wr.data = '{wrapped: 1'b1, len: col_p[COL_W-1:0]};
                next_row    = 1'b1;
              end else begin
                row_wr.data = '{wrapped: 1'b0, len: col_p[COL_W-1:0]};
              end
            end
          end

          OP_LEFT: begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - 1'b1;
              top_nxt     = keep_vis(cur_row_r, top_r);
            end else if (cur_row_r != '0) begin
              cur_row_nxt = rd_row;
              cur_col_nxt = end_col(row_rdata);
              top_nxt     = keep_vis(rd_row, top_r);
            end
          end

          OP_RIGHT: begin
            lim_r = row_rdata.wrapped ? COL_W'(SCREEN_COLS - 1) : row_rdata.len;
            if (cur_col_r < lim_r) begin
              cur_col_nxt = cur_col_r + 1'b1;
              top_nxt     = keep_vis(cur_row_r, top_r);
            end else if (USED_W'(cur_row_r) + 1'b1 < used_r) begin
              cur_row_nxt = cur_row_r + 1'b1;
              cur_col_nxt = '0;
              top_nxt     = keep_vis(cur_row_r + 1'b1, top_r);
            end
          end

          OP_SET_OFF: begin
            state_nxt = S_DIV;
          end

          OP_SET_ABS: begin
            ar = AW'($signed(abs_row_r));
            au = $signed(AW'(used_r)) - AW'(1);
            if (ar < 0) begin
              cur_row_nxt = '0;
            end else if (ar > au) begin
              cur_row_nxt = ROW_W'(au);
            end else begin
              cur_row_nxt = ROW_W'(ar);
            end
            if ($signed(abs_col_r) < 0) begin
              cur_col_nxt = '0;
            end else if ($signed({1'b0, abs_col_r}) > $signed(9'(SCREEN_COLS - 1))) begin
              cur_col_nxt = COL_W'(SCREEN_COLS - 1);
            end else begin
              cur_col_nxt = COL_W'(abs_col_r);
            end
            top_nxt = keep_vis(cur_row_nxt, top_r);
          end

          OP_PAGE_UP: begin
            if (top_r >= ROW_W'(SCREEN_ROWS)) begin
              top_nxt = top_r - ROW_W'(SCREEN_ROWS);
            end else begin
              top_nxt = '0;
            end
          end

          OP_PAGE_DN: begin
            bottom = live_top(used_r);
            sum    = {1'b0, top_r} + (ROW_W+1)'(SCREEN_ROWS);
            if (top_r < bottom) begin
              top_nxt = (sum > {1'b0, bottom}) ? bottom : sum[ROW_W-1:0];
            end
          end

          OP_CLEAR: begin
            rb_nxt      = '0;
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            used_nxt    = USED_W'(1);
            top_nxt     = '0;
            sw_row_nxt  = '0;
            sw_col_nxt  = '0;
            sw_all_nxt  = 1'b1;
            sw_attr_nxt = attr_r;
            state_nxt   = S_SWEEP;
          end

          OP_READ: begin
            cell_nxt = rd_oob ? {attr_r, CH_SPACE} : cell_rdata;
          end

          default: begin
          end
        endcase

        // Advance to a fresh row, dropping the oldest when history is full.
        if (next_row) begin
          cur_col_nxt = '0;
          sw_col_nxt  = '0;
          sw_all_nxt  = 1'b0;
          sw_attr_nxt = attr_r;
          state_nxt   = S_SWEEP;
          if (cur_row_r == ROW_W'(HISTORY_ROWS - 1)) begin
            rb_nxt      = rb_inc;
            used_nxt    = USED_W'(HISTORY_ROWS);
            top_nxt     = (top_r != '0) ? top_r - 1'b1 : '0;
            sw_row_nxt  = rb_r;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            if (used_r < USED_W'(cur_row_r) + USED_W'(2)) begin
              used_nxt = USED_W'(cur_row_r) + USED_W'(2);
            end
            sw_row_nxt = phys(rb_r, cur_row_r + 1'b1);
          end
        end
      end

      S_DIV: begin
        // One column-count subtract per cycle.
        if (rem_r >= 11'(SCREEN_COLS)) begin
          rem_nxt = rem_r - 11'(SCREEN_COLS);
          quo_nxt = quo_r + 1'b1;
        end else begin
          cand        = {1'b0, top_r} + (ROW_W+1)'(quo_r);
          cur_col_nxt = COL_W'(rem_r);
          state_nxt   = S_SNAP;
          if (cand >= (ROW_W+1)'(HISTORY_ROWS)) begin
            rb_nxt      = rb_inc;
            used_nxt    = USED_W'(HISTORY_ROWS);
            top_nxt     = (top_r != '0) ? top_r - 1'b1 : '0;
            cur_row_nxt = ROW_W'(HISTORY_ROWS - 1);
            sw_row_nxt  = rb_r;
            sw_col_nxt  = '0;
            sw_all_nxt  = 1'b0;
            sw_attr_nxt = attr_r;
            state_nxt   = S_SWEEP;
          end else begin
            cur_row_nxt = cand[ROW_W-1:0];
            if (USED_W'(cand) >= used_r) begin
              used_nxt = USED_W'(cand) + 1'b1;
            end
          end
        end
      end

      S_SNAP: begin
        // Put char always snaps the view to the live bottom.
        if (op_r == OP_PUT) begin
          top_nxt = live_top(used_r);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        in_view = (cur_row_r >= top_r) &&
                  ({1'b0, cur_row_r} < {1'b0, top_r} + (ROW_W+1)'(SCREEN_ROWS));
        diff    = QUO_W'(cur_row_r - top_r);
        hw      = in_view ? 11'(diff * 11'(SCREEN_COLS)) + 11'(cur_col_r)
                          : 11'(SCREEN_ROWS * SCREEN_COLS - 1);
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {hw, 8'(used_r), 7'(top_r), 7'(cur_col_r),
                           7'(cur_row_r), cell_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      sw_all_r    <= 1'b1;
      sw_attr_r   <= ATTR_RESET;
      rb_r        <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      used_r      <= USED_W'(1);
      top_r       <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_row_r    <= sw_row_nxt;
      sw_col_r    <= sw_col_nxt;
      sw_all_r    <= sw_all_nxt;
      sw_attr_r   <= sw_attr_nxt;
      rb_r        <= rb_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      used_r      <= used_nxt;
      top_r       <= top_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    abs_row_r  <= abs_row_nxt;
    abs_col_r  <= abs_col_nxt;
    vrow_r     <= vrow_nxt;
    vcol_r     <= vcol_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Row count stays within one and the history depth.
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= USED_W'(HISTORY_ROWS)))
    else $error("rows in use out of range");

  // Between operations the cursor sits on a row in use.
  a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (USED_W'(cur_row_r) < used_r))
    else $error("cursor row beyond rows in use");

  // Between operations the cursor column is on screen.
  a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cur_col_r < COL_W'(SCREEN_COLS)))
    else $error("cursor column off screen");

endmodule
